@@ src/fwpc_pkg.sv @@
package fwpc_pkg;

  // cache geometry
  localparam int unsigned SETS       = 16;
  localparam int unsigned LINE_BYTES = 8;
  localparam int unsigned ADDR_BITS  = 16;
  localparam int unsigned WAYS       = 4;

  localparam int unsigned OFF_BITS  = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS  = $clog2(SETS);
  localparam int unsigned TAG_BITS  = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int unsigned WAY_BITS  = 2;
  localparam int unsigned PLRU_BITS = 3;
  localparam int unsigned CNT_BITS  = 32;

  // result payload: hit, way, write_back and five counters, padded to bytes
  localparam int unsigned RES_BITS     = 1 + WAY_BITS + 1 + 5 * CNT_BITS;
  localparam int unsigned RES_BYTES    = (RES_BITS + 7) / 8;
  localparam int unsigned OUT_DATA_W   = RES_BYTES * 8;
  localparam int unsigned IN_DATA_W    = ((ADDR_BITS + 7) / 8) * 8;

  // one way of a set
  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
  } line_t;

  // one memory row: all ways of a set plus the tree state
  typedef struct packed {
    line_t [WAYS-1:0]     line;
    logic [PLRU_BITS-1:0] plru;
  } row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  // way to evict for each tree state
  localparam logic [WAY_BITS-1:0] VICTIM_OF_STATE [8] = '{
    2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };

  // next tree state, indexed by {state, accessed way}
  localparam logic [PLRU_BITS-1:0] PLRU_NEXT [32] = '{
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2,
    3'd6, 3'd4, 3'd1, 3'd0,
    3'd7, 3'd5, 3'd1, 3'd0,
    3'd6, 3'd4, 3'd3, 3'd2,
    3'd7, 3'd5, 3'd3, 3'd2
  };

endpackage

@@ src/four_way_plru_cache_tag_store.sv @@
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: address; tuser: cmd
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: hit, way, write_back, 5 counters
//
// each access first reads the set's row from the tag memory (synchronous read),
// then updates and writes it back once the output register is free, so one access
// is in flight at a time and the next is taken once the write-back is done.
// a result waits in the output register while the next access is read.
// reset clears the per-set row valid bits at once; a row not yet written reads
// as all zero, so no clearing pass is needed. the counters reset to zero.
module four_way_plru_cache_tag_store
  import fwpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] address
  input  logic                  s_axis_tuser,  // [0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // hit, way[2], write_back, read_count,
                                               // write_count, hit_count, miss_count,
                                               // write_back_count, zero pad
);

  state_e state_q, state_d;

  logic [ADDR_BITS-1:0] addr_q;
  logic                 cmd_q;
  logic [SET_BITS-1:0]  set_q;
  logic [SET_BITS-1:0]  rd_addr;
  logic [SETS-1:0]      row_vld_q;

  row_t tag_mem [SETS];
  row_t rd_data_q;
  row_t row_cur;
  row_t row_new;

  logic [CNT_BITS-1:0] reads_q, writes_q, hits_q, misses_q, evicts_q;
  logic [CNT_BITS-1:0] reads_d, writes_d, hits_d, misses_d, evicts_d;

  logic                  out_valid_q;
  logic [RES_BITS-1:0]   out_data_q;
  logic [RES_BITS-1:0]   res_data;

  logic                  in_acc;
  logic                  out_free;
  logic                  done;
  logic                  hit;
  logic                  wb;
  logic [WAY_BITS-1:0]   way;
  logic [TAG_BITS-1:0]   tag;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign done     = (state_q == ST_LOOKUP) && out_free;

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // capture the transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= s_axis_tdata[ADDR_BITS-1:0];
      cmd_q  <= s_axis_tuser;
      set_q  <= s_axis_tdata[OFF_BITS +: SET_BITS];
    end
  end

  // tag memory, synchronous read, written back at the end of a lookup
  assign rd_addr = in_acc ? s_axis_tdata[OFF_BITS +: SET_BITS] : set_q;

  always_ff @(posedge clk_i) begin
    rd_data_q <= tag_mem[rd_addr];
    if (done) tag_mem[set_q] <= row_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (done) begin
      row_vld_q[set_q] <= 1'b1;
    end
  end

  assign row_cur = row_vld_q[set_q] ? rd_data_q : '0;
  assign tag     = addr_q[ADDR_BITS-1 -: TAG_BITS];

  // hit search, victim choice and row update
  always_comb begin
    logic                found;
    logic                have_inv;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] inv_way;
    found    = 1'b0;
    have_inv = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    // descending so the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_cur.line[w].valid && row_cur.line[w].tag == tag) begin
        found   = 1'b1;
        hit_way = WAY_BITS'(w);
      end
      if (!row_cur.line[w].valid) begin
        have_inv = 1'b1;
        inv_way  = WAY_BITS'(w);
      end
    end
    hit = found;
    if (found) begin
      way = hit_way;
    end else if (have_inv) begin
      way = inv_way;
    end else begin
      way = VICTIM_OF_STATE[row_cur.plru];
    end
    wb = !found && row_cur.line[way].valid && row_cur.line[way].dirty;

    row_new = row_cur;
    if (!found) begin
      row_new.line[way].valid = 1'b1;
      row_new.line[way].dirty = 1'b0;
      row_new.line[way].tag   = tag;
    end
    if (cmd_q) row_new.line[way].dirty = 1'b1;
    row_new.plru = PLRU_NEXT[{row_cur.plru, way}];
  end

  // statistics counters
  assign reads_d  = reads_q + CNT_BITS'(!cmd_q);
  assign writes_d = writes_q + CNT_BITS'(cmd_q);
  assign hits_d   = hits_q + CNT_BITS'(hit);
  assign misses_d = misses_q + CNT_BITS'(!hit);
  assign evicts_d = evicts_q + CNT_BITS'(wb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reads_q  <= '0;
      writes_q <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (done) begin
      reads_q  <= reads_d;
      writes_q <= writes_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  // output register
  assign res_data = {evicts_d, misses_d, hits_d, writes_d, reads_d, wb, way, hit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_data_q <= res_data;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fwpc_pkg::*;

  // access kinds carried on tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned PHASE_ITEMS  = 463;

  // one pending access for the driver
  typedef struct {
    logic [ADDR_BITS-1:0] addr;
    logic                 cmd;
    int unsigned          gap;
    bit                   drain;
  } access_item_t;

  // one result transaction, field by field
  typedef struct {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                wb;
    logic [CNT_BITS-1:0] reads;
    logic [CNT_BITS-1:0] writes;
    logic [CNT_BITS-1:0] hits;
    logic [CNT_BITS-1:0] misses;
    logic [CNT_BITS-1:0] evictions;
  } access_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [15:0] address
  logic                  s_axis_tuser = 1'b0; // [0] cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // hit, way[2], write_back, read_count,
                                              // write_count, hit_count, miss_count,
                                              // write_back_count, zero pad

  access_item_t   pending[$];
  access_result_t results_due[$];

  // tag store as the testbench sees it
  logic                cached_valid [SETS*WAYS];
  logic                cached_dirty [SETS*WAYS];
  logic [TAG_BITS-1:0] cached_tag   [SETS*WAYS];
  logic [2:0]          tree_bits    [SETS];
  logic [CNT_BITS-1:0] n_reads = '0, n_writes = '0, n_hits = '0;
  logic [CNT_BITS-1:0] n_misses = '0, n_evictions = '0;

  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          drv_busy = 1'b0;
  bit          gap_loaded = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  access_item_t cur;

  four_way_plru_cache_tag_store u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // lookup, refill and tree update for one access
  task automatic model_access(input logic [ADDR_BITS-1:0] addr, input logic cmd,
                              output access_result_t r);
    int unsigned         set_idx;
    int unsigned         base;
    logic [TAG_BITS-1:0] tg;
    logic [2:0]          tb;
    logic [WAY_BITS-1:0] w;
    bit                  found;
    set_idx = 32'(addr[OFF_BITS +: SET_BITS]);
    tg      = addr[ADDR_BITS-1 -: TAG_BITS];
    base    = set_idx * WAYS;
    tb      = tree_bits[set_idx];
    found   = 1'b0;
    w       = '0;
    r.wb    = 1'b0;
    if (cmd == CMD_WRITE) n_writes++;
    else n_reads++;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (cached_valid[base + i] && cached_tag[base + i] == tg) begin
        found = 1'b1;
        w = WAY_BITS'(i);
      end
    end
    if (found) begin
      n_hits++;
    end else begin
      n_misses++;
      // tree victim, overridden by the lowest invalid way
      w = tb[2] ? {1'b1, tb[0]} : {1'b0, tb[1]};
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (!cached_valid[base + i]) w = WAY_BITS'(i);
      end
      if (cached_valid[base + w] && cached_dirty[base + w]) begin
        r.wb = 1'b1;
        n_evictions++;
      end
      cached_valid[base + w] = 1'b1;
      cached_dirty[base + w] = 1'b0;
      cached_tag[base + w]   = tg;
    end
    // point the tree away from the accessed way
    case (w)
      2'd0: begin tb[2] = 1'b1; tb[1] = 1'b1; end
      2'd1: begin tb[2] = 1'b1; tb[1] = 1'b0; end
      2'd2: begin tb[2] = 1'b0; tb[0] = 1'b1; end
      default: begin tb[2] = 1'b0; tb[0] = 1'b0; end
    endcase
    tree_bits[set_idx] = tb;
    if (cmd == CMD_WRITE) cached_dirty[base + w] = 1'b1;
    r.hit       = found;
    r.way       = w;
    r.reads     = n_reads;
    r.writes    = n_writes;
    r.hits      = n_hits;
    r.misses    = n_misses;
    r.evictions = n_evictions;
  endtask

  task automatic check_field(input string name, input logic [CNT_BITS-1:0] want,
                             input logic [CNT_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic add_item(input logic [ADDR_BITS-1:0] addr, input logic cmd,
                          input int unsigned gap, input bit drain);
    access_item_t it;
    it.addr  = addr;
    it.cmd   = cmd;
    it.gap   = gap;
    it.drain = drain;
    pending.push_back(it);
  endtask

  // predict on each accepted access, check each accepted result
  always @(posedge clk_i) begin
    access_result_t want;
    access_result_t got;
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        model_access(s_axis_tdata[ADDR_BITS-1:0], s_axis_tuser, want);
        results_due.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit       = m_axis_tdata[0];
        got.way       = m_axis_tdata[2:1];
        got.wb        = m_axis_tdata[3];
        got.reads     = m_axis_tdata[4 +: CNT_BITS];
        got.writes    = m_axis_tdata[4 + CNT_BITS +: CNT_BITS];
        got.hits      = m_axis_tdata[4 + 2*CNT_BITS +: CNT_BITS];
        got.misses    = m_axis_tdata[4 + 3*CNT_BITS +: CNT_BITS];
        got.evictions = m_axis_tdata[4 + 4*CNT_BITS +: CNT_BITS];
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("hit", CNT_BITS'(want.hit), CNT_BITS'(got.hit));
          check_field("way", CNT_BITS'(want.way), CNT_BITS'(got.way));
          check_field("write_back", CNT_BITS'(want.wb), CNT_BITS'(got.wb));
          check_field("read_count", want.reads, got.reads);
          check_field("write_count", want.writes, got.writes);
          check_field("hit_count", want.hits, got.hits);
          check_field("miss_count", want.misses, got.misses);
          check_field("write_back_count", want.evictions, got.evictions);
        end
      end
    end
  end

  // access driver
  always @(negedge clk_i) begin
    logic vld;
    vld = s_axis_tvalid;
    if (rst_ni) begin
      if (drv_busy && in_taken) begin
        drv_busy = 1'b0;
        vld = 1'b0;
      end
      if (!drv_busy && pending.size() != 0) begin
        if (!gap_loaded) begin
          gap_left = pending[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].drain || results_due.size() == 0) begin
          cur = pending.pop_front();
          drv_busy = 1'b1;
          gap_loaded = 1'b0;
          vld = 1'b1;
          s_axis_tdata <= cur.addr;
          s_axis_tuser <= cur.cmd;
        end
      end
    end
    s_axis_tvalid <= vld;
  end

  // result receiver with random stalls and stall-free windows
  always @(negedge clk_i) begin
    logic rdy;
    rdy = m_axis_tready;
    if (rst_ni) begin
      if (out_taken) begin
        if ((cycle_cnt / 1500) % 4 == 1) stall_left = 0;
        else stall_left = $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else begin
        rdy = 1'b1;
      end
    end
    m_axis_tready <= rdy;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned set_base;
    int unsigned tag_base;
    int unsigned gap;
    bit          quiet;
    logic [TAG_BITS-1:0] tg;
    logic [SET_BITS-1:0] st;
    logic [OFF_BITS-1:0] off;
    logic [ADDR_BITS-1:0] a;

    for (int i = 0; i < SETS*WAYS; i++) begin
      cached_valid[i] = 1'b0;
      cached_dirty[i] = 1'b0;
      cached_tag[i]   = '0;
    end
    for (int i = 0; i < SETS; i++) tree_bits[i] = '0;

    // directed: cold misses, hits, address extremes
    add_item(16'h0000, CMD_READ, 0, 1'b0);
    add_item(16'h0000, CMD_READ, 0, 1'b0);
    add_item(16'h0007, CMD_WRITE, 1, 1'b0);
    add_item(16'hFFFF, CMD_WRITE, 0, 1'b0);
    add_item(16'hFFF8, CMD_READ, 3, 1'b0);
    add_item(16'hAAAA, CMD_READ, 0, 1'b0);
    add_item(16'h5555, CMD_WRITE, 0, 1'b0);
    // fill the rest of set zero, then conflict misses with dirty victims
    add_item(16'h0080, CMD_WRITE, 0, 1'b0);
    add_item(16'h0100, CMD_READ, 0, 1'b0);
    add_item(16'h0180, CMD_WRITE, 2, 1'b0);
    add_item(16'h0200, CMD_READ, 0, 1'b0);
    add_item(16'h0280, CMD_WRITE, 0, 1'b0);
    add_item(16'h0300, CMD_WRITE, 0, 1'b0);
    add_item(16'h0380, CMD_WRITE, 0, 1'b0);
    add_item(16'h0400, CMD_READ, 0, 1'b0);
    add_item(16'h0480, CMD_READ, 0, 1'b0);
    add_item(16'h0500, CMD_READ, 1, 1'b0);
    add_item(16'h0280, CMD_READ, 0, 1'b0);
    add_item(16'h0300, CMD_WRITE, 0, 1'b0);
    add_item(16'h0000, CMD_WRITE, 0, 1'b0);
    add_item(16'hFFFF, CMD_READ, 0, 1'b0);

    // random phases over a few hot sets and tags, with some scattered accesses
    for (int p = 0; p < PHASES; p++) begin
      set_base = $urandom_range(0, SETS - 4);
      tag_base = $urandom_range(0, 500);
      quiet = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        gap = quiet ? 0 : $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 3) begin
          a = ADDR_BITS'($urandom_range(0, 16'hFFFF));
        end else begin
          tg  = TAG_BITS'(tag_base + $urandom_range(0, 5));
          st  = SET_BITS'(set_base + $urandom_range(0, 3));
          off = OFF_BITS'($urandom_range(0, LINE_BYTES - 1));
          a   = {tg, st, off};
        end
        add_item(a, 1'($urandom_range(0, 1)), gap, i == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || drv_busy || results_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && results_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
